// ===== sv/eulrb_pkg.sv =====
// Package with the word types, constants and rounding helper of the Euler basis unit.
package eulrb_pkg;

    // One input word: three binary angles.
    typedef struct packed {
        logic [15:0] yaw;
        logic [15:0] pitch;
        logic [15:0] roll;
    } angles_t;

    // One output word: forward, left and up basis vectors in signed fixed point.
    typedef struct packed {
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] left_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } basis_t;

    // Working precision of sine and cosine: Q30.
    localparam int WQ = 30;
    localparam logic [30:0] HALF_PI = 31'd1686629713;
    localparam logic signed [31:0] ONE_W = 32'sd1073741824;
    localparam int SERIES_TERMS = 8;

    // Pipeline depths of the two units.
    localparam int TRIG_LAT = 3 + 2 * SERIES_TERMS + 1;
    localparam int BASIS_LAT = 5;

    // Shift right by s with rounding to nearest, halves away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic        neg;
        logic [63:0] m;
        begin
            neg = v[63];
            m = neg ? (64'd0 - 64'(v)) : 64'(v);
            m = (m + (64'd1 << (s - 1))) >> s;
            rnd_shift = neg ? -$signed(m) : $signed(m);
        end
    endfunction

endpackage

// ===== sv/eulrb_trig.sv =====
// Pipelined sine and cosine of one binary angle by a Taylor series in Q30.
module eulrb_trig #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [31:0] sin_reg,
    output logic signed [31:0] cos_reg
);

    localparam int AW = ANGLE_BITS;
    localparam int RW = AW - 2;
    localparam int PW = RW + 31;
    localparam int NT = eulrb_pkg::SERIES_TERMS;

    logic [AW-1:0] ang;
    assign ang = AW'(angle);

    // Stage 1: scale the in-quadrant offset by pi/2.
    logic [1:0]    quad1_reg;
    logic [PW-1:0] prod1_reg;
    // Stage 2: rounded angle in radians, Q30.
    logic [1:0]    quad2_reg;
    logic [30:0]   x2r_reg;
    // Stage 3: square of the angle.
    logic [1:0]    quad3_reg;
    logic [30:0]   x3_reg;
    logic [61:0]   xx3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad1_reg <= ang[AW-1:AW-2];
            prod1_reg <= PW'(ang[RW-1:0]) * PW'(eulrb_pkg::HALF_PI);
            quad2_reg <= quad1_reg;
            x2r_reg   <= 31'(((PW+1)'(prod1_reg) + ((PW+1)'(1) << (RW - 1))) >> RW);
            quad3_reg <= quad2_reg;
            x3_reg    <= x2r_reg;
            xx3_reg   <= 62'(x2r_reg) * 62'(x2r_reg);
        end
    end

    // Series steps: each term takes a multiply by x^2 and a multiply by a reciprocal.
    logic [31:0]        ts_in [1:NT];
    logic [31:0]        tc_in [1:NT];
    logic [31:0]        sq_in [1:NT];
    logic signed [33:0] ss_in [1:NT];
    logic signed [33:0] cc_in [1:NT];
    logic [1:0]         q_in  [1:NT];

    logic [63:0]        pas_reg [1:NT];
    logic [63:0]        pac_reg [1:NT];
    logic [31:0]        sqa_reg [1:NT];
    logic signed [33:0] ssa_reg [1:NT];
    logic signed [33:0] cca_reg [1:NT];
    logic [1:0]         qa_reg  [1:NT];

    logic [65:0]        pbs_reg [1:NT];
    logic [65:0]        pbc_reg [1:NT];
    logic [31:0]        sqb_reg [1:NT];
    logic signed [33:0] ssb_reg [1:NT];
    logic signed [33:0] ccb_reg [1:NT];
    logic [1:0]         qb_reg  [1:NT];

    logic [31:0]        term_s [1:NT];
    logic [31:0]        term_c [1:NT];

    // First step starts from x and one.
    assign ts_in[1] = 32'(x3_reg);
    assign tc_in[1] = 32'(eulrb_pkg::ONE_W);
    assign sq_in[1] = 32'(xx3_reg >> eulrb_pkg::WQ);
    assign ss_in[1] = 34'(x3_reg);
    assign cc_in[1] = 34'(eulrb_pkg::ONE_W);
    assign q_in[1]  = quad3_reg;

    for (genvar k = 1; k <= NT; k++)
    begin : g_step
        localparam int DS = (2 * k) * (2 * k + 1);
        localparam int DC = (2 * k - 1) * (2 * k);
        localparam int LS = $clog2(DS);
        localparam int LC = $clog2(DC);
        localparam logic [63:0] MS = ((64'd1 << (32 + LS)) + 64'(DS) - 64'd1) / 64'(DS);
        localparam logic [63:0] MC = ((64'd1 << (32 + LC)) + 64'(DC) - 64'd1) / 64'(DC);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pas_reg[k] <= 64'(ts_in[k]) * 64'(sq_in[k]);
                pac_reg[k] <= 64'(tc_in[k]) * 64'(sq_in[k]);
                sqa_reg[k] <= sq_in[k];
                ssa_reg[k] <= ss_in[k];
                cca_reg[k] <= cc_in[k];
                qa_reg[k]  <= q_in[k];
                pbs_reg[k] <= 66'(pas_reg[k][63:30]) * 66'(MS[33:0]);
                pbc_reg[k] <= 66'(pac_reg[k][63:30]) * 66'(MC[33:0]);
                sqb_reg[k] <= sqa_reg[k];
                ssb_reg[k] <= ssa_reg[k];
                ccb_reg[k] <= cca_reg[k];
                qb_reg[k]  <= qa_reg[k];
            end
        end

        // Exact floor division by the step's constant divisor.
        assign term_s[k] = 32'(pbs_reg[k] >> (32 + LS));
        assign term_c[k] = 32'(pbc_reg[k] >> (32 + LC));

        // Feed the next step, adding this term with its alternating sign.
        if (k < NT)
        begin : g_next
            assign ts_in[k+1] = term_s[k];
            assign tc_in[k+1] = term_c[k];
            assign sq_in[k+1] = sqb_reg[k];
            assign q_in[k+1]  = qb_reg[k];
            if (k % 2 == 1)
            begin : g_sub
                assign ss_in[k+1] = ssb_reg[k] - $signed(34'(term_s[k]));
                assign cc_in[k+1] = ccb_reg[k] - $signed(34'(term_c[k]));
            end
            else
            begin : g_add
                assign ss_in[k+1] = ssb_reg[k] + $signed(34'(term_s[k]));
                assign cc_in[k+1] = ccb_reg[k] + $signed(34'(term_c[k]));
            end
        end
    end

    // Last term, clamp to [0, 1] and quadrant mapping.
    logic signed [33:0] ss_f;
    logic signed [33:0] cc_f;
    logic signed [31:0] s_cl;
    logic signed [31:0] c_cl;

    always_comb
    begin
        if (NT % 2 == 1)
        begin
            ss_f = ssb_reg[NT] - $signed(34'(term_s[NT]));
            cc_f = ccb_reg[NT] - $signed(34'(term_c[NT]));
        end
        else
        begin
            ss_f = ssb_reg[NT] + $signed(34'(term_s[NT]));
            cc_f = ccb_reg[NT] + $signed(34'(term_c[NT]));
        end
        if (ss_f < 0)
            s_cl = '0;
        else if (ss_f > 34'(eulrb_pkg::ONE_W))
            s_cl = eulrb_pkg::ONE_W;
        else
            s_cl = 32'(ss_f);
        if (cc_f < 0)
            c_cl = '0;
        else if (cc_f > 34'(eulrb_pkg::ONE_W))
            c_cl = eulrb_pkg::ONE_W;
        else
            c_cl = 32'(cc_f);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (qb_reg[NT])
                2'd0:
                begin
                    sin_reg <= s_cl;
                    cos_reg <= c_cl;
                end
                2'd1:
                begin
                    sin_reg <= c_cl;
                    cos_reg <= -s_cl;
                end
                2'd2:
                begin
                    sin_reg <= -s_cl;
                    cos_reg <= -c_cl;
                end
                default:
                begin
                    sin_reg <= -c_cl;
                    cos_reg <= s_cl;
                end
            endcase
        end
    end

endmodule

// ===== sv/eulrb_basis.sv =====
// Pipelined products, sums and output rounding of the rotation basis.
module eulrb_basis #(
    parameter int FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  sy,
    input  logic signed [31:0]  cy,
    input  logic signed [31:0]  sp,
    input  logic signed [31:0]  cp,
    input  logic signed [31:0]  sr,
    input  logic signed [31:0]  cr,
    output eulrb_pkg::basis_t   basis_reg
);

    localparam int OSH = 2 * eulrb_pkg::WQ - FRAC_BITS;
    localparam logic signed [63:0] LIM = 64'sd1 << FRAC_BITS;

    // Stage 1: two-factor products.
    logic signed [63:0] cpcy1_reg, cpsy1_reg, srcp1_reg, crcp1_reg;
    logic signed [63:0] crsy1_reg, crcy1_reg, srsy1_reg, srcy1_reg;
    logic signed [63:0] srsp1_reg, crsp1_reg;
    logic signed [31:0] sp1_reg, cy1_reg, sy1_reg;
    // Stage 2: roll by pitch-sine products rounded back to Q30, the others delayed.
    logic signed [63:0] cpcy2_reg, cpsy2_reg, srcp2_reg, crcp2_reg;
    logic signed [63:0] crsy2_reg, crcy2_reg, srsy2_reg, srcy2_reg;
    logic signed [31:0] srsp2_reg, crsp2_reg, sp2_reg, cy2_reg, sy2_reg;
    // Stage 3: three-factor products.
    logic signed [63:0] cpcy3_reg, cpsy3_reg, srcp3_reg, crcp3_reg;
    logic signed [63:0] crsy3_reg, crcy3_reg, srsy3_reg, srcy3_reg;
    logic signed [63:0] m_lx3_reg, m_ly3_reg, m_ux3_reg, m_uy3_reg;
    logic signed [31:0] sp3_reg;
    // Stage 4: sums in Q60.
    logic signed [63:0] v4_reg [0:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpcy1_reg <= 64'(cp) * 64'(cy);
            cpsy1_reg <= 64'(cp) * 64'(sy);
            srcp1_reg <= 64'(sr) * 64'(cp);
            crcp1_reg <= 64'(cr) * 64'(cp);
            crsy1_reg <= 64'(cr) * 64'(sy);
            crcy1_reg <= 64'(cr) * 64'(cy);
            srsy1_reg <= 64'(sr) * 64'(sy);
            srcy1_reg <= 64'(sr) * 64'(cy);
            srsp1_reg <= 64'(sr) * 64'(sp);
            crsp1_reg <= 64'(cr) * 64'(sp);
            sp1_reg   <= sp;
            cy1_reg   <= cy;
            sy1_reg   <= sy;

            cpcy2_reg <= cpcy1_reg;
            cpsy2_reg <= cpsy1_reg;
            srcp2_reg <= srcp1_reg;
            crcp2_reg <= crcp1_reg;
            crsy2_reg <= crsy1_reg;
            crcy2_reg <= crcy1_reg;
            srsy2_reg <= srsy1_reg;
            srcy2_reg <= srcy1_reg;
            srsp2_reg <= 32'(eulrb_pkg::rnd_shift(srsp1_reg, eulrb_pkg::WQ));
            crsp2_reg <= 32'(eulrb_pkg::rnd_shift(crsp1_reg, eulrb_pkg::WQ));
            sp2_reg   <= sp1_reg;
            cy2_reg   <= cy1_reg;
            sy2_reg   <= sy1_reg;

            cpcy3_reg <= cpcy2_reg;
            cpsy3_reg <= cpsy2_reg;
            srcp3_reg <= srcp2_reg;
            crcp3_reg <= crcp2_reg;
            crsy3_reg <= crsy2_reg;
            crcy3_reg <= crcy2_reg;
            srsy3_reg <= srsy2_reg;
            srcy3_reg <= srcy2_reg;
            m_lx3_reg <= 64'(srsp2_reg) * 64'(cy2_reg);
            m_ly3_reg <= 64'(srsp2_reg) * 64'(sy2_reg);
            m_ux3_reg <= 64'(crsp2_reg) * 64'(cy2_reg);
            m_uy3_reg <= 64'(crsp2_reg) * 64'(sy2_reg);
            sp3_reg   <= sp2_reg;

            v4_reg[0] <= cpcy3_reg;
            v4_reg[1] <= cpsy3_reg;
            v4_reg[2] <= -(64'(sp3_reg) <<< eulrb_pkg::WQ);
            v4_reg[3] <= m_lx3_reg - crsy3_reg;
            v4_reg[4] <= m_ly3_reg + crcy3_reg;
            v4_reg[5] <= srcp3_reg;
            v4_reg[6] <= m_ux3_reg + srsy3_reg;
            v4_reg[7] <= m_uy3_reg - srcy3_reg;
            v4_reg[8] <= crcp3_reg;
        end
    end

    // Stage 5: round to the output format and clamp to plus or minus one.
    logic [15:0] o_next [0:8];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            logic signed [63:0] r;
            r = eulrb_pkg::rnd_shift(v4_reg[i], OSH);
            if (r > LIM)
                r = LIM;
            else if (r < -LIM)
                r = -LIM;
            o_next[i] = r[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            basis_reg.fwd_x  <= o_next[0];
            basis_reg.fwd_y  <= o_next[1];
            basis_reg.fwd_z  <= o_next[2];
            basis_reg.left_x <= o_next[3];
            basis_reg.left_y <= o_next[4];
            basis_reg.left_z <= o_next[5];
            basis_reg.up_x   <= o_next[6];
            basis_reg.up_y   <= o_next[7];
            basis_reg.up_z   <= o_next[8];
        end
    end

endmodule

// ===== sv/euler_to_rotation_basis_unit.sv =====
// Top level of the Euler yaw-pitch-roll to rotation basis unit.
//
// The input channel (in_valid, in_ready, in_data) takes one word of yaw, pitch
// and roll binary angles. The output channel (out_valid, out_ready, out_data)
// gives one word of nine basis components in signed fixed point for each input
// word, in order.
// Each word passes first through the sine and cosine series (angle scaling, a
// multiply by x^2 and a multiply by a reciprocal per term over eight terms, and
// the quadrant mapping) and then through the basis products, sums and rounding.
// One word per cycle unless stalled; the three angles run in parallel units.
// Reset clears all valid bits, so the pipeline comes up empty and in_ready
// is high.
// When the receiver stalls with a finished word waiting, the whole pipeline
// holds and in_ready drops. While the last stage is empty, the pipeline keeps
// advancing and words keep entering; gaps between words move along unchanged.
module euler_to_rotation_basis_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  eulrb_pkg::angles_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output eulrb_pkg::basis_t    out_data
);

    localparam int LAT = eulrb_pkg::TRIG_LAT + eulrb_pkg::BASIS_LAT;

    logic [LAT-1:0] vld_reg;
    logic           en;

    // The pipeline advances unless a finished word is waiting.
    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    // Valid bits travel alongside the data stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    logic signed [31:0] sy, cy, sp, cp, sr, cr;

    // One sine and cosine unit per angle.
    eulrb_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_yaw (
        .clk     (clk),
        .en      (en),
        .angle   (in_data.yaw),
        .sin_reg (sy),
        .cos_reg (cy)
    );

    eulrb_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_pitch (
        .clk     (clk),
        .en      (en),
        .angle   (in_data.pitch),
        .sin_reg (sp),
        .cos_reg (cp)
    );

    eulrb_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_roll (
        .clk     (clk),
        .en      (en),
        .angle   (in_data.roll),
        .sin_reg (sr),
        .cos_reg (cr)
    );

    // Basis products and output rounding.
    eulrb_basis #(.FRAC_BITS(FRAC_BITS)) u_basis (
        .clk       (clk),
        .en        (en),
        .sy        (sy),
        .cy        (cy),
        .sp        (sp),
        .cp        (cp),
        .sr        (sr),
        .cr        (cr),
        .basis_reg (out_data)
    );

endmodule
